### hw/rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// JSON structural tokenizer package
// Shared types and code values for the tokenizer and its testbench.
// ----------------------------------------------------------------------------
package jst_pkg;

  // Field widths fixed by the record format.
  localparam int unsigned IdxW   = 20;
  localparam int unsigned CountW = 20;
  localparam int unsigned NextW  = 21;
  localparam int unsigned PosW   = 32;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [8:0] DepthLimitReset = 9'd200;

  typedef enum logic [1:0] {
    RK_START = 2'd0,
    RK_CLOSE = 2'd1,
    RK_DONE  = 2'd2,
    RK_ERROR = 2'd3
  } rec_kind_e;

  typedef enum logic [2:0] {
    TY_OBJ   = 3'd0,
    TY_ARR   = 3'd1,
    TY_KEY   = 3'd2,
    TY_STR   = 3'd3,
    TY_NUM   = 3'd4,
    TY_NULL  = 3'd5,
    TY_TRUE  = 3'd6,
    TY_FALSE = 3'd7
  } tok_type_e;

  typedef enum logic [3:0] {
    ER_BAD_START   = 4'd0,
    ER_DEPTH       = 4'd1,
    ER_AFTER_BRACE = 4'd2,
    ER_NO_COLON    = 4'd3,
    ER_KEY_VALUE   = 4'd4,
    ER_ARR_VALUE   = 4'd5,
    ER_AFTER_OBJV  = 4'd6,
    ER_NO_KEY      = 4'd7,
    ER_AFTER_ARRV  = 4'd8,
    ER_TRAILING    = 4'd9,
    ER_UNTERM      = 4'd10
  } err_code_e;

  typedef enum logic [3:0] {
    PH_ROOT        = 4'd0,
    PH_OBJ_OPEN    = 4'd1,
    PH_KEY_STR     = 4'd2,
    PH_AFTER_KEY   = 4'd3,
    PH_KEY_VALUE   = 4'd4,
    PH_ARR_OPEN    = 4'd5,
    PH_VAL_STR     = 4'd6,
    PH_NUMBER      = 4'd7,
    PH_SKIP        = 4'd8,
    PH_AFTER_VALUE = 4'd9,
    PH_OBJ_COMMA   = 4'd10,
    PH_DONE_ROOT   = 4'd11,
    PH_HALT        = 4'd12,
    PH_ARR_COMMA   = 4'd13
  } phase_e;

  // One container level; an open key is kept as a flag on its object.
  typedef struct packed {
    logic              is_arr;
    logic [IdxW-1:0]   index;
    logic [CountW-1:0] count;
    logic              key_open;
    logic [IdxW-1:0]   key_index;
  } level_t;

  // One output record.
  typedef struct packed {
    rec_kind_e         kind;
    tok_type_e         ttype;
    logic [IdxW-1:0]   index;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] count;
    logic [NextW-1:0]  next;
    err_code_e         err;
    logic              last;
  } rec_t;

  function automatic rec_t mk_rec(rec_kind_e kind, tok_type_e ttype,
                                  logic [IdxW-1:0] index, logic [PosW-1:0] pos,
                                  logic [CountW-1:0] count, logic [NextW-1:0] next,
                                  err_code_e err);
    rec_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.index = index;
    r.pos   = pos;
    r.count = count;
    r.next  = next;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

### hw/rtl/jst_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/json_structural_tokenizer.sv
// ----------------------------------------------------------------------------
// JSON structural tokenizer
// Splits a JSON byte stream into token start, close, done and error records.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one text byte per transaction in tdata; tuser set
// marks the end of the text. Each byte yields zero to three records on the
// master stream; tlast flags the last record caused by one input transaction.
// A record is registered into the output queue when its byte is taken.
// One byte is taken every cycle as long as the four-entry output queue has
// room for three records; a byte that yields several records holds the input
// for as many cycles as the receiver needs to drain them. The loop that sets
// the rate is the stack top update: the top two levels sit in registers and
// deeper levels in a RAM with registered read, prefetched one pop ahead.
// When the receiver stalls the queue fills and s_axis_tready drops.
// Reset empties the queue and restarts parsing at the root; the depth limit
// returns to 200. After a done or error record the block drops all input
// until the next reset. cfg_we_i writes the depth limit from cfg_wdata_i.
// ----------------------------------------------------------------------------
module json_structural_tokenizer #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned MAX_TOKENS  = 1048576
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // text_byte
  input  logic          s_axis_tuser,   // end_of_text
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // token_type[2:0], token_index[22:3], byte_position[54:23], item_count[74:55],
  // next_index[95:75], error_code[99:96], zero fill
  output logic [103:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // record_kind
  output logic          m_axis_tlast    // last_of_run
);
  import jst_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam int unsigned TW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned LvW = $bits(level_t);
  localparam int unsigned QD = 4;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  // Parser state.
  phase_e          phase_q, phase_d;
  logic [CW-1:0]   dep_q, dep_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [TW-1:0]   tc_q, tc_d;
  logic [PosW-1:0] bc_q, bc_d;
  logic [2:0]      skip_q, skip_d;
  logic            esc_q, esc_d;
  logic [8:0]      lim_q;
  level_t          top_q, top_d, sec_q, sec_d;

  // Stack RAM and write forwarding.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [LvW-1:0]  mem_rdata;
  logic [AW-1:0]   raddr_q;
  logic            fwd_vld_q;
  logic [AW-1:0]   fwd_addr_q;
  level_t          fwd_data_q;
  level_t          below;

  // Output queue.
  rec_t            q_q [QD];
  logic [QAW-1:0]  wp_q, rp_q;
  logic [QCW-1:0]  qcnt_q;
  rec_t            recs [3];
  logic [1:0]      nrec;
  logic            in_acc, out_acc;

  jst_ram #(.Width(LvW), .Depth(STACK_DEPTH)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(sec_q),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign below = (fwd_vld_q && fwd_addr_q == raddr_q) ? fwd_data_q : level_t'(mem_rdata);
  assign s_axis_tready = qcnt_q <= QCW'(1);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign mem_waddr = AW'(cnt_q - CW'(2));
  assign mem_raddr = AW'(cnt_d - CW'(3));

  // Per-byte parse step.
  always_comb begin
    logic [7:0]      c;
    logic [PosW-1:0] pos;
    level_t          top;
    logic [IdxW-1:0] idx;
    logic            sv_en, sv_arr, do_push, do_close, do_vd, fail_en, at_lim;
    err_code_e       sv_err, fail_code;
    tok_type_e       push_ty;
    logic [LW-1:0]   lim;

    c = s_axis_tdata;
    pos = bc_q;
    top = top_q;
    idx = '0;
    sv_en = 1'b0; sv_arr = 1'b0; do_push = 1'b0; do_close = 1'b0;
    do_vd = 1'b0; fail_en = 1'b0; at_lim = 1'b0;
    sv_err = ER_BAD_START; fail_code = ER_BAD_START; push_ty = TY_OBJ;
    lim = (LW'(lim_q) < LW'(STACK_DEPTH)) ? LW'(lim_q) : LW'(STACK_DEPTH);
    phase_d = phase_q; dep_d = dep_q; cnt_d = cnt_q; tc_d = tc_q; bc_d = bc_q;
    skip_d = skip_q; esc_d = esc_q; sec_d = sec_q;
    mem_we = 1'b0;
    nrec = '0;
    for (int i = 0; i < 3; i++) begin
      recs[i] = '0;
    end

    if (in_acc && phase_q != PH_HALT) begin
      if (s_axis_tuser) begin
        // End of text.
        if (phase_q == PH_DONE_ROOT) begin
          recs[0] = mk_rec(RK_DONE, TY_OBJ, '0, bc_q, '0, NextW'(tc_q), ER_BAD_START);
          nrec = 2'd1;
          phase_d = PH_HALT;
        end else begin
          fail_en = 1'b1;
          fail_code = (phase_q == PH_ROOT) ? ER_BAD_START : ER_UNTERM;
        end
      end else begin
        bc_d = bc_q + PosW'(1);
        // A number ends at the first byte outside its character set.
        if (phase_d == PH_NUMBER) begin
          if (!(c inside {["0":"9"], ".", "-", "+", "e", "E"})) begin
            if (top.key_open) begin
              recs[nrec] = mk_rec(RK_CLOSE, TY_KEY, top.key_index, '0, CountW'(1),
                                  NextW'(tc_q), ER_BAD_START);
              nrec = nrec + 2'd1;
              top.key_open = 1'b0;
              dep_d = dep_d - CW'(1);
            end
            phase_d = (cnt_d == '0) ? PH_DONE_ROOT : PH_AFTER_VALUE;
          end
        end
        if (phase_d == PH_NUMBER) begin
          // Still inside the number.
        end else if (phase_d == PH_KEY_STR || phase_d == PH_VAL_STR) begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (c == "\\") begin
            esc_d = 1'b1;
          end else if (c == "\"") begin
            if (phase_d == PH_KEY_STR) phase_d = PH_AFTER_KEY;
            else do_vd = 1'b1;
          end
        end else if (phase_d == PH_SKIP) begin
          if (skip_q != '0) skip_d = skip_q - 3'd1;
          if (skip_d == '0) do_vd = 1'b1;
        end else if (!(c inside {" ", 8'h09, 8'h0A, 8'h0D})) begin
          case (phase_d)
            PH_ROOT: begin
              if (c == "{" || c == "[") begin
                do_push = 1'b1;
                push_ty = (c == "[") ? TY_ARR : TY_OBJ;
              end else begin
                fail_en = 1'b1; fail_code = ER_BAD_START;
              end
            end
            PH_OBJ_OPEN, PH_OBJ_COMMA: begin
              if (c == "\"") begin
                do_push = 1'b1; push_ty = TY_KEY;
              end else if (c == "}" && phase_d == PH_OBJ_OPEN) begin
                do_close = 1'b1;
              end else begin
                fail_en = 1'b1;
                fail_code = (phase_d == PH_OBJ_OPEN) ? ER_AFTER_BRACE : ER_NO_KEY;
              end
            end
            PH_AFTER_KEY: begin
              if (c == ":") phase_d = PH_KEY_VALUE;
              else begin
                fail_en = 1'b1; fail_code = ER_NO_COLON;
              end
            end
            PH_KEY_VALUE: begin
              sv_en = 1'b1; sv_err = ER_KEY_VALUE;
            end
            PH_ARR_OPEN, PH_ARR_COMMA: begin
              if (c == "]" && phase_d == PH_ARR_OPEN) do_close = 1'b1;
              else begin
                sv_en = 1'b1; sv_arr = 1'b1; sv_err = ER_ARR_VALUE;
              end
            end
            PH_AFTER_VALUE: begin
              if (cnt_d == '0) begin
                fail_en = 1'b1; fail_code = ER_TRAILING;
              end else if (c == ",") begin
                phase_d = top.is_arr ? PH_ARR_COMMA : PH_OBJ_COMMA;
              end else if ((top.is_arr && c == "]") || (!top.is_arr && c == "}")) begin
                do_close = 1'b1;
              end else begin
                fail_en = 1'b1;
                fail_code = top.is_arr ? ER_AFTER_ARRV : ER_AFTER_OBJV;
              end
            end
            PH_DONE_ROOT: begin
              fail_en = 1'b1; fail_code = ER_TRAILING;
            end
            default: phase_d = PH_HALT;
          endcase
        end

        // Value start in a key or array slot.
        if (sv_en) begin
          if (!(c inside {"{", "[", "\"", "-", ["0":"9"], "n", "t", "f"})) begin
            fail_en = 1'b1; fail_code = sv_err;
          end else begin
            if (sv_arr && cnt_d != '0 && top.count != CountMax) begin
              top.count = top.count + CountW'(1);
            end
            if (c == "{" || c == "[") begin
              do_push = 1'b1;
              push_ty = (c == "[") ? TY_ARR : TY_OBJ;
            end else begin
              idx = (tc_q < TW'(MAX_TOKENS)) ? IdxW'(tc_q) : IdxW'(MAX_TOKENS - 1);
              if (tc_q < TW'(MAX_TOKENS)) tc_d = tc_q + TW'(1);
              case (c)
                "\"": begin push_ty = TY_STR; phase_d = PH_VAL_STR; esc_d = 1'b0; end
                "n": begin push_ty = TY_NULL; phase_d = PH_SKIP; skip_d = 3'd3; end
                "t": begin push_ty = TY_TRUE; phase_d = PH_SKIP; skip_d = 3'd3; end
                "f": begin push_ty = TY_FALSE; phase_d = PH_SKIP; skip_d = 3'd4; end
                default: begin push_ty = TY_NUM; phase_d = PH_NUMBER; end
              endcase
              recs[nrec] = mk_rec(RK_START, push_ty, idx, pos, '0, '0, ER_BAD_START);
              nrec = nrec + 2'd1;
            end
          end
        end

        // Open an object, an array or a key level.
        if (do_push) begin
          if (push_ty == TY_KEY && cnt_d != '0 && top.count != CountMax) begin
            top.count = top.count + CountW'(1);
          end
          at_lim = LW'(dep_d) >= lim;
          if (at_lim) begin
            fail_en = 1'b1; fail_code = ER_DEPTH;
          end else begin
            idx = (tc_q < TW'(MAX_TOKENS)) ? IdxW'(tc_q) : IdxW'(MAX_TOKENS - 1);
            if (tc_q < TW'(MAX_TOKENS)) tc_d = tc_q + TW'(1);
            dep_d = dep_d + CW'(1);
            if (push_ty == TY_KEY) begin
              top.key_open = 1'b1;
              top.key_index = idx;
              phase_d = PH_KEY_STR;
              esc_d = 1'b0;
            end else begin
              mem_we = cnt_q >= CW'(2);
              sec_d = top;
              top.is_arr = (push_ty == TY_ARR);
              top.index = idx;
              top.count = '0;
              top.key_open = 1'b0;
              top.key_index = '0;
              cnt_d = cnt_d + CW'(1);
              phase_d = (push_ty == TY_ARR) ? PH_ARR_OPEN : PH_OBJ_OPEN;
            end
            recs[nrec] = mk_rec(RK_START, push_ty, idx, pos, '0, '0, ER_BAD_START);
            nrec = nrec + 2'd1;
          end
        end

        // Close the top container and pop the stack.
        if (do_close) begin
          recs[nrec] = mk_rec(RK_CLOSE, top.is_arr ? TY_ARR : TY_OBJ, top.index, '0,
                              top.count, NextW'(tc_q), ER_BAD_START);
          nrec = nrec + 2'd1;
          dep_d = dep_d - CW'(1);
          cnt_d = cnt_d - CW'(1);
          top = sec_q;
          sec_d = below;
          do_vd = 1'b1;
        end

        // A value is complete: close a pending key.
        if (do_vd) begin
          if (cnt_d != '0 && top.key_open) begin
            recs[nrec] = mk_rec(RK_CLOSE, TY_KEY, top.key_index, '0, CountW'(1),
                                NextW'(tc_q), ER_BAD_START);
            nrec = nrec + 2'd1;
            top.key_open = 1'b0;
            dep_d = dep_d - CW'(1);
          end
          phase_d = (cnt_d == '0) ? PH_DONE_ROOT : PH_AFTER_VALUE;
        end
      end

      // Error record halts the parser.
      if (fail_en) begin
        recs[nrec] = mk_rec(RK_ERROR, TY_OBJ, '0, pos, '0, '0, fail_code);
        nrec = nrec + 2'd1;
        phase_d = PH_HALT;
      end
      if (nrec != '0) recs[nrec - 2'd1].last = 1'b1;
    end
    top_d = top;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ROOT;
      dep_q <= '0;
      cnt_q <= '0;
      tc_q <= '0;
      bc_q <= '0;
      skip_q <= '0;
      esc_q <= 1'b0;
      lim_q <= DepthLimitReset;
      fwd_vld_q <= 1'b0;
      wp_q <= '0;
      rp_q <= '0;
      qcnt_q <= '0;
    end else begin
      phase_q <= phase_d;
      dep_q <= dep_d;
      cnt_q <= cnt_d;
      tc_q <= tc_d;
      bc_q <= bc_d;
      skip_q <= skip_d;
      esc_q <= esc_d;
      if (cfg_we_i) lim_q <= cfg_wdata_i;
      fwd_vld_q <= mem_we;
      wp_q <= wp_q + QAW'(nrec);
      rp_q <= rp_q + QAW'(out_acc);
      qcnt_q <= qcnt_q + QCW'(nrec) - QCW'(out_acc);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
    raddr_q <= mem_raddr;
    fwd_addr_q <= mem_waddr;
    fwd_data_q <= sec_q;
    for (int i = 0; i < 3; i++) begin
      if (nrec > 2'(i)) q_q[wp_q + QAW'(i)] <= recs[i];
    end
  end

  // Output stream.
  assign m_axis_tvalid = qcnt_q != '0;
  assign m_axis_tdata = {4'b0, q_q[rp_q].err, q_q[rp_q].next, q_q[rp_q].count,
                         q_q[rp_q].pos, q_q[rp_q].index, q_q[rp_q].ttype};
  assign m_axis_tuser = q_q[rp_q].kind;
  assign m_axis_tlast = q_q[rp_q].last;

endmodule

### bench/tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer record checker
// Watches the configuration port and both streams of the tokenizer. It
// predicts the records that each accepted byte causes and compares every
// record that leaves the block, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tokenizer_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o,
  output int           checked_o
);
  import jst_pkg::*;

  localparam int unsigned MaxDepth  = 256;
  localparam int unsigned MaxTokens = 1048576;
  localparam err_code_e   NoErr     = ER_BAD_START;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  ttype;
    logic [19:0] index;
    logic [31:0] pos;
    logic [19:0] count;
    logic [20:0] next;
    logic [3:0]  err;
    logic        last;
  } token_rec_t;

  token_rec_t  record_q[$];

  // Predicted parser state.
  tok_type_e   lvl_type  [MaxDepth];
  int unsigned lvl_index [MaxDepth];
  int unsigned lvl_count [MaxDepth];
  int unsigned depth;
  int unsigned tok_count;
  int unsigned skip_left;
  int unsigned depth_lim;
  int unsigned step_recs;
  logic [31:0] byte_count;
  phase_e      phase;

  // Queue one predicted record; a byte causes at most three.
  task automatic emit(rec_kind_e kind, tok_type_e ty, int unsigned idx, logic [31:0] pos,
                      int unsigned cnt, int unsigned nxt, err_code_e code);
    token_rec_t r;
    if (step_recs < 3) begin
      r.kind  = kind;
      r.ttype = ty;
      r.index = idx[19:0];
      r.pos   = pos;
      r.count = cnt[19:0];
      r.next  = nxt[20:0];
      r.err   = code;
      r.last  = 1'b0;
      record_q.push_back(r);
      step_recs++;
    end
  endtask

  task automatic raise_error(err_code_e code, logic [31:0] pos);
    emit(RK_ERROR, TY_OBJ, 0, pos, 0, 0, code);
    phase = PH_HALT;
  endtask

  function automatic int unsigned take_index();
    int unsigned idx;
    if (tok_count < MaxTokens) begin
      idx = tok_count;
      tok_count++;
    end else begin
      idx = MaxTokens - 1;
    end
    return idx;
  endfunction

  task automatic bump_top();
    if (depth > 0 && lvl_count[depth-1] < CountMax) lvl_count[depth-1]++;
  endtask

  task automatic open_level(tok_type_e ty, logic [31:0] pos, output bit ok);
    int unsigned lim;
    int unsigned idx;
    lim = (depth_lim < MaxDepth) ? depth_lim : MaxDepth;
    if (depth >= lim) begin
      raise_error(ER_DEPTH, pos);
      ok = 1'b0;
    end else begin
      idx = take_index();
      lvl_type[depth]  = ty;
      lvl_index[depth] = idx;
      lvl_count[depth] = 0;
      depth++;
      emit(RK_START, ty, idx, pos, 0, 0, NoErr);
      ok = 1'b1;
    end
  endtask

  // A finished value also closes the key that holds it.
  task automatic value_done();
    if (depth > 0 && lvl_type[depth-1] == TY_KEY) begin
      emit(RK_CLOSE, TY_KEY, lvl_index[depth-1], 0, 1, tok_count, NoErr);
      depth--;
    end
    phase = (depth == 0) ? PH_DONE_ROOT : PH_AFTER_VALUE;
  endtask

  task automatic close_level();
    if (depth != 0) begin
      emit(RK_CLOSE, lvl_type[depth-1], lvl_index[depth-1], 0, lvl_count[depth-1],
           tok_count, NoErr);
      depth--;
      value_done();
    end
  endtask

  task automatic start_scalar(tok_type_e ty, logic [31:0] pos, phase_e ph, int unsigned skip);
    emit(RK_START, ty, take_index(), pos, 0, 0, NoErr);
    phase     = ph;
    skip_left = skip;
  endtask

  task automatic start_value(logic [7:0] c, logic [31:0] pos, err_code_e code, bit in_arr);
    bit ok;
    bit pushed;
    ok = (c == ChLBrace) || (c == ChLBrack) || (c == ChQuote) || (c == "-") ||
         (c >= "0" && c <= "9") || (c == "n") || (c == "t") || (c == "f");
    if (!ok) begin
      raise_error(code, pos);
    end else begin
      if (in_arr) bump_top();
      if (c == ChLBrace) begin
        open_level(TY_OBJ, pos, pushed);
        if (pushed) phase = PH_OBJ_OPEN;
      end else if (c == ChLBrack) begin
        open_level(TY_ARR, pos, pushed);
        if (pushed) phase = PH_ARR_OPEN;
      end else if (c == ChQuote) begin
        start_scalar(TY_STR, pos, PH_VAL_STR, 0);
      end else if (c == "n") begin
        start_scalar(TY_NULL, pos, PH_SKIP, 3);
      end else if (c == "t") begin
        start_scalar(TY_TRUE, pos, PH_SKIP, 3);
      end else if (c == "f") begin
        start_scalar(TY_FALSE, pos, PH_SKIP, 4);
      end else begin
        start_scalar(TY_NUM, pos, PH_NUMBER, 0);
      end
    end
  endtask

  task automatic start_key(logic [31:0] pos);
    bit pushed;
    bump_top();
    open_level(TY_KEY, pos, pushed);
    if (pushed) begin
      phase     = PH_KEY_STR;
      skip_left = 0;
    end
  endtask

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic bit is_num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "-" || c == "+" ||
           c == "e" || c == "E";
  endfunction

  task automatic take_byte(logic [7:0] c, logic [31:0] pos);
    if (phase == PH_NUMBER) begin
      if (is_num_char(c)) return;
      value_done();
    end
    // Inside a string only the closing quote and escapes matter.
    if (phase == PH_KEY_STR || phase == PH_VAL_STR) begin
      if (skip_left != 0) begin
        skip_left = 0;
      end else if (c == ChBslash) begin
        skip_left = 1;
      end else if (c == ChQuote) begin
        if (phase == PH_KEY_STR) phase = PH_AFTER_KEY;
        else value_done();
      end
      return;
    end
    // Literal letters are counted, not checked.
    if (phase == PH_SKIP) begin
      if (skip_left > 0) skip_left--;
      if (skip_left == 0) value_done();
      return;
    end
    if (phase == PH_HALT || is_blank(c)) return;
    case (phase)
      PH_ROOT: begin
        if (c == ChLBrace || c == ChLBrack) start_value(c, pos, ER_BAD_START, 1'b0);
        else raise_error(ER_BAD_START, pos);
      end
      PH_OBJ_OPEN: begin
        if (c == ChQuote) start_key(pos);
        else if (c == ChRBrace) close_level();
        else raise_error(ER_AFTER_BRACE, pos);
      end
      PH_OBJ_COMMA: begin
        if (c == ChQuote) start_key(pos);
        else raise_error(ER_NO_KEY, pos);
      end
      PH_AFTER_KEY: begin
        if (c == ChColon) phase = PH_KEY_VALUE;
        else raise_error(ER_NO_COLON, pos);
      end
      PH_KEY_VALUE: start_value(c, pos, ER_KEY_VALUE, 1'b0);
      PH_ARR_OPEN: begin
        if (c == ChRBrack) close_level();
        else start_value(c, pos, ER_ARR_VALUE, 1'b1);
      end
      PH_ARR_COMMA: start_value(c, pos, ER_ARR_VALUE, 1'b1);
      PH_AFTER_VALUE: begin
        if (depth == 0) begin
          raise_error(ER_TRAILING, pos);
        end else if (lvl_type[depth-1] == TY_ARR) begin
          if (c == ChComma) phase = PH_ARR_COMMA;
          else if (c == ChRBrack) close_level();
          else raise_error(ER_AFTER_ARRV, pos);
        end else begin
          if (c == ChComma) phase = PH_OBJ_COMMA;
          else if (c == ChRBrace) close_level();
          else raise_error(ER_AFTER_OBJV, pos);
        end
      end
      PH_DONE_ROOT: raise_error(ER_TRAILING, pos);
      default: phase = PH_HALT;
    endcase
  endtask

  // Predict all records of one input transaction.
  task automatic predict_item(logic [7:0] c, logic eot);
    logic [31:0] pos;
    step_recs = 0;
    if (phase != PH_HALT) begin
      if (eot) begin
        if (phase == PH_DONE_ROOT) begin
          emit(RK_DONE, TY_OBJ, 0, byte_count, 0, tok_count, NoErr);
          phase = PH_HALT;
        end else if (phase == PH_ROOT) begin
          raise_error(ER_BAD_START, byte_count);
        end else begin
          raise_error(ER_UNTERM, byte_count);
        end
      end else begin
        pos        = byte_count;
        byte_count = byte_count + 1;
        take_byte(c, pos);
      end
      if (step_recs > 0) record_q[record_q.size()-1].last = 1'b1;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_record();
    token_rec_t r;
    if (record_q.size() == 0) begin
      $error("record: unexpected transaction, kind 0x%0h", m_axis_tuser);
      fail_count_o++;
    end else begin
      r = record_q.pop_front();
      check_field("record_kind", r.kind, m_axis_tuser);
      check_field("token_type", r.ttype, m_axis_tdata[2:0]);
      check_field("token_index", r.index, m_axis_tdata[22:3]);
      check_field("byte_position", r.pos, m_axis_tdata[54:23]);
      check_field("item_count", r.count, m_axis_tdata[74:55]);
      check_field("next_index", r.next, m_axis_tdata[95:75]);
      check_field("error_code", r.err, m_axis_tdata[99:96]);
      check_field("last_of_run", r.last, m_axis_tlast);
      checked_o++;
    end
  endtask

  // Prediction runs before the check; a record never leaves in its byte's cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_q.delete();
      for (int i = 0; i < MaxDepth; i++) begin
        lvl_type[i]  = TY_OBJ;
        lvl_index[i] = 0;
        lvl_count[i] = 0;
      end
      depth        = 0;
      tok_count    = 0;
      skip_left    = 0;
      depth_lim    = 32'(DepthLimitReset);
      byte_count   = '0;
      phase        = PH_ROOT;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) depth_lim = 32'(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_record();
    end
    pending_o = record_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON structural tokenizer testbench
// Streams one long JSON document through the tokenizer: a directed opening,
// a nest up to a depth limit of 64, and random well-formed values under
// several depth limits, with random gaps on both streams and a long receiver
// stall.
// ----------------------------------------------------------------------------
module testbench;
  import jst_pkg::*;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [8:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int hold_req = 0;
  int holds_done = 0;
  logic [7:0] text_q[$];

  json_structural_tokenizer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  tokenizer_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: random stalls per record, with bursts and one long hold-off.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_req != holds_done) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        holds_done++;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  // Offer one byte or end marker and wait for its transaction.
  task automatic send_item(logic [7:0] b, logic eot);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= eot;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  // Stop offering and wait until every predicted record has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_depth_limit(logic [8:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_blank();
    int n;
    logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
    n = $urandom_range(0, 5);
    if (n < 3) repeat (n) text_q.push_back(blanks[$urandom_range(0, 3)]);
  endfunction

  // String body bytes are random; quote and backslash only appear escaped.
  function automatic void add_string();
    int len;
    logic [7:0] c;
    text_q.push_back(ChQuote);
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        text_q.push_back(ChBslash);
        text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == ChQuote || c == ChBslash);
        text_q.push_back(c);
      end
    end
    text_q.push_back(ChQuote);
  endfunction

  // Well-formed value that opens at most room levels below the current one.
  function automatic void add_value(int room, int nest);
    int pick;
    int n;
    string num_chars = "0123456789.-+eE";
    pick = $urandom_range(0, 9);
    if (pick < 2 && room >= 1 && nest < 4) begin
      text_q.push_back(ChLBrack);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) text_q.push_back(ChComma);
        add_blank();
        add_value(room - 1, nest + 1);
        add_blank();
      end
      text_q.push_back(ChRBrack);
    end else if (pick < 4 && room >= 1 && nest < 4) begin
      text_q.push_back(ChLBrace);
      n = (room >= 2) ? $urandom_range(0, 3) : 0;
      for (int i = 0; i < n; i++) begin
        if (i > 0) text_q.push_back(ChComma);
        add_blank();
        add_string();
        add_blank();
        text_q.push_back(ChColon);
        add_blank();
        add_value(room - 2, nest + 1);
        add_blank();
      end
      text_q.push_back(ChRBrace);
    end else if (pick < 6) begin
      add_string();
    end else if (pick < 8) begin
      text_q.push_back(8'(($urandom_range(0, 1) == 0) ? "-" : ("0" + $urandom_range(0, 9))));
      repeat ($urandom_range(0, 5)) text_q.push_back(num_chars[$urandom_range(0, 14)]);
    end else begin
      // Literal letters after the first are not checked by the block.
      n = $urandom_range(0, 2);
      text_q.push_back((n == 0) ? "n" : ((n == 1) ? "t" : "f"));
      repeat ((n == 2) ? 4 : 3) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Random elements appended to the root array.
  task automatic random_elements(int target, int room);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      text_q.delete();
      text_q.push_back(ChComma);
      add_blank();
      add_value(room, 0);
      add_blank();
      foreach (text_q[i]) send_item(text_q[i], 1'b0);
      if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed opening: every token type but false, empty containers, escapes.
    send_text(" [{\"\\\"\":-1E+5,\"\":[true]},{},[],null,\"\\\\\"\t\r\n");

    // Nest up to the depth limit with the receiver held off and no sender gaps.
    set_depth_limit(9'd64);
    tx_burst = 1'b1;
    hold_req++;
    send_item(ChComma, 1'b0);
    repeat (63) send_item(ChLBrack, 1'b0);
    send_item("7", 1'b0);
    repeat (63) send_item(ChRBrack, 1'b0);
    tx_burst = 1'b0;

    // Random values under several limits; above 256 acts as 256.
    set_depth_limit(9'd511);
    random_elements(90, 255);
    set_depth_limit(9'd5);
    random_elements(70, 4);
    set_depth_limit(9'd2);
    random_elements(50, 1);
    set_depth_limit(9'd1);
    random_elements(40, 0);

    // Close the root, end the text, then bytes that the halted block drops.
    set_depth_limit(DepthLimitReset);
    send_item(ChRBrack, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d input transactions in one document, checked %0d records.",
             bytes_sent, checked);
    $display("Depth limits 200, 64, 511, 5, 2 and 1, with gaps and a long output stall.");
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
